// File: hdl/apic_pkg.sv
package apic_pkg;

  localparam int unsigned NUM_POL   = 3;
  localparam int unsigned NUM_BP    = 6;
  localparam int unsigned NUM_CAT   = 6;
  localparam int unsigned CONC_W    = 16;
  localparam int unsigned API_W     = 13;
  localparam int unsigned SEG_W     = 3;
  localparam int unsigned X_W       = 10;
  localparam int unsigned M_W       = 25;
  localparam int unsigned Q_W       = 11;
  localparam int unsigned SHIFT     = 20;
  localparam int unsigned PROD_W    = X_W + M_W;

  typedef enum logic [1:0] {
    POL_SO2  = 2'd0,
    POL_NO2  = 2'd1,
    POL_PM10 = 2'd2
  } apic_pol_e;

  typedef struct packed {
    logic [CONC_W-1:0] so2_conc;
    logic [CONC_W-1:0] no2_conc;
    logic [CONC_W-1:0] pm10_conc;
  } apic_in_t;

  typedef struct packed {
    logic [API_W-1:0] api_level;
    logic [2:0]       category;
    logic [1:0]       dominant;
  } apic_out_t;

  typedef struct packed {
    logic mul;
    logic sub;
  } apic_ld_t;

  localparam logic [CONC_W-1:0] BP_C [NUM_POL][NUM_BP] = '{
    '{16'd50, 16'd150, 16'd800, 16'd1600, 16'd2100, 16'd2620},
    '{16'd80, 16'd120, 16'd280, 16'd565,  16'd750,  16'd940},
    '{16'd50, 16'd150, 16'd350, 16'd420,  16'd500,  16'd600}
  };

  localparam logic [CONC_W-1:0] LO_C [NUM_POL][NUM_BP] = '{
    '{16'd0, 16'd50, 16'd150, 16'd800, 16'd1600, 16'd2100},
    '{16'd0, 16'd80, 16'd120, 16'd280, 16'd565,  16'd750},
    '{16'd0, 16'd50, 16'd150, 16'd350, 16'd420,  16'd500}
  };

  // lower end of each segment in Q4
  localparam logic [API_W-1:0] BASE_IDX [NUM_BP] = '{
    13'd0, 13'd800, 13'd1600, 13'd3200, 13'd4800, 13'd6400
  };

  localparam logic [API_W-1:0] API_MAX = 13'd8000;

  // ceil(span_q4 * 2^20 / width), exact for every offset below the width
  localparam logic [M_W-1:0] SLOPE_M [NUM_POL][NUM_BP] = '{
    '{25'((800 * 2**20 + 49) / 50),    25'((800 * 2**20 + 99) / 100),
      25'((1600 * 2**20 + 649) / 650), 25'((1600 * 2**20 + 799) / 800),
      25'((1600 * 2**20 + 499) / 500), 25'((1600 * 2**20 + 519) / 520)},
    '{25'((800 * 2**20 + 79) / 80),    25'((800 * 2**20 + 39) / 40),
      25'((1600 * 2**20 + 159) / 160), 25'((1600 * 2**20 + 284) / 285),
      25'((1600 * 2**20 + 184) / 185), 25'((1600 * 2**20 + 189) / 190)},
    '{25'((800 * 2**20 + 49) / 50),    25'((800 * 2**20 + 99) / 100),
      25'((1600 * 2**20 + 199) / 200), 25'((1600 * 2**20 + 69) / 70),
      25'((1600 * 2**20 + 79) / 80),   25'((1600 * 2**20 + 99) / 100)}
  };

  // api_level >= 16 + 800*(n+1) moves the category past band n
  localparam logic [API_W-1:0] CAT_THR [NUM_CAT] = '{
    13'd816, 13'd1616, 13'd2416, 13'd3216, 13'd4016, 13'd4816
  };

endpackage

// File: hdl/apic_sub.sv
module apic_sub (
  input  logic                         clk_i,
  input  apic_pkg::apic_ld_t           ld_i,
  input  logic [apic_pkg::CONC_W-1:0]  conc_i [apic_pkg::NUM_POL],
  output logic [apic_pkg::API_W-1:0]   sub_o  [apic_pkg::NUM_POL]
);
  import apic_pkg::*;

  logic [SEG_W-1:0]  seg    [NUM_POL];
  logic              sat_d  [NUM_POL];
  logic              sat_q  [NUM_POL];
  logic [X_W-1:0]    x_d    [NUM_POL];
  logic [X_W-1:0]    x_q    [NUM_POL];
  logic [M_W-1:0]    m_d    [NUM_POL];
  logic [M_W-1:0]    m_q    [NUM_POL];
  logic [API_W-1:0]  base_d [NUM_POL];
  logic [API_W-1:0]  base_q [NUM_POL];
  logic [PROD_W-1:0] prod   [NUM_POL];
  logic [API_W-1:0]  sub_d  [NUM_POL];
  logic [API_W-1:0]  sub_q  [NUM_POL];

  // segment lookup: first breakpoint above the value
  always_comb begin
    for (int p = 0; p < NUM_POL; p++) begin
      seg[p]   = SEG_W'(NUM_BP - 1);
      sat_d[p] = conc_i[p] >= BP_C[p][NUM_BP-1];
      for (int k = NUM_BP - 1; k >= 0; k--) begin
        if (conc_i[p] < BP_C[p][k]) begin
          seg[p] = SEG_W'(k);
        end
      end
      x_d[p]    = X_W'(conc_i[p] - LO_C[p][seg[p]]);
      m_d[p]    = SLOPE_M[p][seg[p]];
      base_d[p] = BASE_IDX[seg[p]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.mul) begin
      for (int p = 0; p < NUM_POL; p++) begin
        x_q[p]    <= x_d[p];
        m_q[p]    <= m_d[p];
        base_q[p] <= base_d[p];
        sat_q[p]  <= sat_d[p];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_POL; p++) begin
      prod[p]  = PROD_W'(x_q[p]) * PROD_W'(m_q[p]);
      sub_d[p] = sat_q[p] ? API_MAX : base_q[p] + API_W'(prod[p][SHIFT +: Q_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.sub) begin
      for (int p = 0; p < NUM_POL; p++) begin
        sub_q[p] <= sub_d[p];
      end
    end
  end

  assign sub_o = sub_q;

endmodule

// File: hdl/apic_sel.sv
module apic_sel (
  input  logic [apic_pkg::API_W-1:0] sub_i [apic_pkg::NUM_POL],
  output apic_pkg::apic_out_t        res_o
);
  import apic_pkg::*;

  logic [API_W-1:0] best;
  apic_pol_e        dom;
  logic [2:0]       cat;

  // earliest pollutant keeps ties
  always_comb begin
    best = sub_i[0];
    dom  = POL_SO2;
    for (int p = 1; p < NUM_POL; p++) begin
      if (best < sub_i[p]) begin
        best = sub_i[p];
        dom  = apic_pol_e'(2'(p));
      end
    end
    cat = 3'd0;
    for (int j = 0; j < NUM_CAT; j++) begin
      if (best >= CAT_THR[j]) begin
        cat = cat + 3'd1;
      end
    end
    res_o.api_level = best;
    res_o.category  = cat;
    res_o.dominant  = dom;
  end

endmodule

// File: hdl/air_pollution_index_calc.sv
// channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------
// input    | valid_i  | stall_o  | in_item_i  (so2/no2/pm10 conc, 16b ea)
// output   | valid_o  | stall_i  | out_item_o (api_level, category, dominant)
//
// Four register stages: input, segment, product, result. One item per cycle
// sustained while stall_i is low; the three lane multipliers set the stage.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled result holds in the output register; earlier stages keep
// accepting until every stage is full.
module air_pollution_index_calc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  apic_pkg::apic_in_t  in_item_i,
  output logic                valid_o,
  input  logic                stall_i,
  output apic_pkg::apic_out_t out_item_o
);
  import apic_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q;
  logic v0_d, v1_d, v2_d, v3_d;
  logic rdy0, rdy1, rdy2, rdy3;
  logic ld0, ld3;
  apic_ld_t          ld;
  apic_in_t          in_q;
  apic_out_t         res;
  apic_out_t         out_q;
  logic [CONC_W-1:0] conc [NUM_POL];
  logic [API_W-1:0]  sub  [NUM_POL];

  always_comb begin
    rdy3   = !v3_q || !stall_i;
    rdy2   = !v2_q || rdy3;
    rdy1   = !v1_q || rdy2;
    rdy0   = !v0_q || rdy1;
    ld0    = valid_i && rdy0;
    ld.mul = v0_q && rdy1;
    ld.sub = v1_q && rdy2;
    ld3    = v2_q && rdy3;
    v0_d   = rdy0 ? valid_i : v0_q;
    v1_d   = rdy1 ? v0_q : v1_q;
    v2_d   = rdy2 ? v1_q : v2_q;
    v3_d   = rdy3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      in_q <= in_item_i;
    end
  end

  assign conc[POL_SO2]  = in_q.so2_conc;
  assign conc[POL_NO2]  = in_q.no2_conc;
  assign conc[POL_PM10] = in_q.pm10_conc;

  apic_sub u_sub (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .conc_i (conc),
    .sub_o  (sub)
  );

  apic_sel u_sel (
    .sub_i (sub),
    .res_o (res)
  );

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      out_q <= res;
    end
  end

  assign stall_o    = !rdy0;
  assign valid_o    = v3_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_api_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_item_o.api_level <= API_MAX)
    else $error("api_level above saturation");

  a_cat_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_item_o.api_level < CAT_THR[0] |-> out_item_o.category == 3'd0)
    else $error("category nonzero below first band");

  a_cat_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_item_o.api_level >= CAT_THR[NUM_CAT-1]
      |-> out_item_o.category == 3'(NUM_CAT))
    else $error("category not capped");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && v1_q && v2_q && v3_q && stall_i |-> stall_o)
    else $error("input taken with full stalled pipeline");
`endif

endmodule
